// ===== hw/rtl/round_robin_slice_scheduler_top_defines.svh =====
// Assertion macros shared by the scheduler's checker.
// Both sample on i_clk and are disabled while i_rst_n is low.
`ifndef ROUND_ROBIN_SLICE_SCHEDULER_TOP_DEFINES_SVH
`define ROUND_ROBIN_SLICE_SCHEDULER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RRSS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RRSS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/rrss_pkg.sv =====
`default_nettype none

package rrss_pkg;

    // Table depth and the widths that follow from it.
    localparam int MAX_TASKS = 16;
    localparam int IDX_W     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W     = $clog2(MAX_TASKS + 1);

    // Field widths of a request and a result.
    localparam int ACT_W   = 2;
    localparam int ID_W    = 8;
    localparam int BURST_W = 16;

    // Action codes carried by a request.
    localparam logic [ACT_W-1:0] ACT_LOAD  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_SCHED = 2'd1;
    localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;

    // Quantum after reset.
    localparam logic [BURST_W-1:0] QUANTUM_RESET = 16'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;   // append the request's task to the table
        logic clear;  // empty the table
        logic find;   // capture the next entry with work left
        logic read;   // read the captured entry from the table
        logic grant;  // subtract the slice, write back, report the grant
        logic drop;   // report a load into a full table
        logic done;   // report that no task has work left
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic full;   // table holds MAX_TASKS entries
        logic found;  // the last search found an entry with work left
    } t_status;

endpackage

`default_nettype wire

// ===== hw/rtl/rrss_ctrl.sv =====
`default_nettype none

module rrss_ctrl (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [rrss_pkg::ACT_W-1:0] i_action,
    input  rrss_pkg::t_status               i_status,
    output logic                            o_busy,
    output rrss_pkg::t_cmd                  o_cmd
);
    import rrss_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_GRANT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_busy;
    logic   accept;

    assign accept = i_start && !r_busy;
    assign o_busy = r_busy;

    // Next state and commands for the datapath.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_action)
                        ACT_LOAD: begin
                            if (i_status.full) begin
                                o_cmd.drop = 1'b1;
                            end else begin
                                o_cmd.load = 1'b1;
                            end
                        end
                        ACT_SCHED: begin
                            o_cmd.find = 1'b1;
                            n_state    = S_READ;
                        end
                        ACT_CLEAR: begin
                            o_cmd.clear = 1'b1;
                        end
                        default: begin
                            // The unused code is ignored.
                        end
                    endcase
                end
            end
            S_READ: begin
                if (i_status.found) begin
                    o_cmd.read = 1'b1;
                    n_state    = S_GRANT;
                end else begin
                    o_cmd.done = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_GRANT: begin
                o_cmd.grant = 1'b1;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and the registered busy flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= (n_state != S_IDLE);
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/rrss_dp.sv =====
`default_nettype none

module rrss_dp (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  rrss_pkg::t_cmd                    i_cmd,
    output rrss_pkg::t_status                 o_status,
    input  wire logic                         i_cfg_we,
    input  wire logic [rrss_pkg::BURST_W-1:0] i_cfg_wdata,
    input  wire logic [rrss_pkg::ID_W-1:0]    i_task_id,
    input  wire logic [rrss_pkg::BURST_W-1:0] i_burst_length,
    output logic                              o_strobe,
    output logic [rrss_pkg::ID_W-1:0]         o_granted_id,
    output logic [rrss_pkg::BURST_W-1:0]      o_slice_length,
    output logic                              o_task_finished,
    output logic                              o_all_done,
    output logic                              o_load_dropped
);
    import rrss_pkg::*;

    // Task table.
    logic [ID_W-1:0]    r_mem_id    [MAX_TASKS];
    logic [BURST_W-1:0] r_mem_burst [MAX_TASKS];
    // One flag per entry: the entry still has work left.
    logic [MAX_TASKS-1:0] r_nz;

    logic [BURST_W-1:0] r_quantum;
    logic [CNT_W-1:0]   r_count;
    logic [IDX_W-1:0]   r_scan;
    logic [IDX_W-1:0]   r_idx;
    logic               r_found;
    logic [ID_W-1:0]    r_rd_id;
    logic [BURST_W-1:0] r_rd_burst;

    logic               r_strobe;
    logic [ID_W-1:0]    r_granted_id;
    logic [BURST_W-1:0] r_slice_length;
    logic               r_task_finished;
    logic               r_all_done;
    logic               r_load_dropped;

    logic [IDX_W-1:0]   start_pos;
    logic [MAX_TASKS-1:0] active;
    logic [MAX_TASKS-1:0] upper;
    logic [IDX_W-1:0]   find_idx;
    logic               find_any;
    logic [BURST_W-1:0] slice;
    logic [BURST_W-1:0] rem;
    logic [CNT_W-1:0]   idx_next;
    logic [IDX_W-1:0]   load_addr;
    logic [IDX_W-1:0]   wr_addr;
    logic [BURST_W-1:0] wr_burst;
    logic               wr_en;

    // Lowest set bit of a mask.
    function automatic logic [IDX_W-1:0] lowest_set(input logic [MAX_TASKS-1:0] mask);
        logic [IDX_W-1:0] idx;
        idx = '0;
        for (int i = MAX_TASKS - 1; i >= 0; i--) begin
            if (mask[i]) begin
                idx = IDX_W'(i);
            end
        end
        return idx;
    endfunction

    assign o_status.full  = (r_count == CNT_W'(MAX_TASKS));
    assign o_status.found = r_found;

    // The search starts at the scan position, or at entry zero when that lies
    // beyond the loaded tasks.
    assign start_pos = (CNT_W'(r_scan) >= r_count) ? '0 : r_scan;

    // Entries with work left, and those among them at or after the start.
    always_comb begin
        for (int i = 0; i < MAX_TASKS; i++) begin
            active[i] = r_nz[i] && (CNT_W'(i) < r_count);
            upper[i]  = active[i] && (IDX_W'(i) >= start_pos);
        end
    end

    // Wrap around to the lowest entry when nothing lies after the start.
    assign find_any = |active;
    assign find_idx = (|upper) ? lowest_set(upper) : lowest_set(active);

    // Slice arithmetic on the entry read from the table.
    assign slice    = (r_rd_burst < r_quantum) ? r_rd_burst : r_quantum;
    assign rem      = r_rd_burst - slice;
    assign idx_next = CNT_W'(r_idx) + CNT_W'(1);

    // One write port: loads append, grants write the burst back.
    assign load_addr = r_count[IDX_W-1:0];
    assign wr_en     = i_cmd.load || i_cmd.grant;
    assign wr_addr   = i_cmd.grant ? r_idx : load_addr;
    assign wr_burst  = i_cmd.grant ? rem : i_burst_length;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem_burst[wr_addr] <= wr_burst;
            r_nz[wr_addr]        <= (wr_burst != '0);
        end
        if (i_cmd.load) begin
            r_mem_id[load_addr] <= i_task_id;
        end
    end

    // Registered table read of the entry found by the search.
    always_ff @(posedge i_clk) begin
        if (i_cmd.read) begin
            r_rd_id    <= r_mem_id[r_idx];
            r_rd_burst <= r_mem_burst[r_idx];
        end
    end

    // Search result.
    always_ff @(posedge i_clk) begin
        if (i_cmd.find) begin
            r_idx   <= find_idx;
            r_found <= find_any;
        end
    end

    // Quantum register, task count and scan position.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quantum <= QUANTUM_RESET;
            r_count   <= '0;
            r_scan    <= '0;
        end else begin
            if (i_cfg_we) begin
                r_quantum <= i_cfg_wdata;
            end
            if (i_cmd.clear) begin
                r_count <= '0;
                r_scan  <= '0;
            end else if (i_cmd.load) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (i_cmd.grant) begin
                r_scan <= (idx_next < r_count) ? idx_next[IDX_W-1:0] : '0;
            end
        end
    end

    // Result strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.grant || i_cmd.done || i_cmd.drop;
        end
    end

    // Result fields.
    always_ff @(posedge i_clk) begin
        if (i_cmd.grant) begin
            r_granted_id    <= r_rd_id;
            r_slice_length  <= slice;
            r_task_finished <= (rem == '0);
            r_all_done      <= 1'b0;
            r_load_dropped  <= 1'b0;
        end else if (i_cmd.done || i_cmd.drop) begin
            r_granted_id    <= '0;
            r_slice_length  <= '0;
            r_task_finished <= 1'b0;
            r_all_done      <= i_cmd.done;
            r_load_dropped  <= i_cmd.drop;
        end
    end

    assign o_strobe        = r_strobe;
    assign o_granted_id    = r_granted_id;
    assign o_slice_length  = r_slice_length;
    assign o_task_finished = r_task_finished;
    assign o_all_done      = r_all_done;
    assign o_load_dropped  = r_load_dropped;

endmodule

`default_nettype wire

// ===== hw/rtl/round_robin_slice_scheduler_top.sv =====
// Round-robin time-slice scheduler. A request is taken when start is high and
// busy is low. A load or clear request leaves busy low, so another request can
// follow at once; only a load into a full table answers, with o_load_dropped.
// A schedule request runs a priority search over the per-entry work-left
// flags, a registered table read and the subtract and write-back, which is
// skipped when no entry has work left; busy is high for the read and write-back
// steps. Every schedule request answers with a grant or with o_all_done. A
// result is shown for exactly one cycle with o_strobe, one cycle after the
// request's last step, and must be captured then: the receiver cannot stall
// the block. The quantum is to be written through i_cfg_we / i_cfg_wdata only
// while the block is idle; the block does not enforce this. It resets to 2.
`default_nettype none

module round_robin_slice_scheduler_top (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [rrss_pkg::ACT_W-1:0]   i_action,
    input  wire logic [rrss_pkg::ID_W-1:0]    i_task_id,
    input  wire logic [rrss_pkg::BURST_W-1:0] i_burst_length,
    input  wire logic                         i_cfg_we,
    input  wire logic [rrss_pkg::BURST_W-1:0] i_cfg_wdata,
    output logic                              o_strobe,
    output logic [rrss_pkg::ID_W-1:0]         o_granted_id,
    output logic [rrss_pkg::BURST_W-1:0]      o_slice_length,
    output logic                              o_task_finished,
    output logic                              o_all_done,
    output logic                              o_load_dropped
);
    import rrss_pkg::*;

    t_cmd    cmd;
    t_status status;

    // Sequencer.
    rrss_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_action (i_action),
        .i_status (status),
        .o_busy   (busy),
        .o_cmd    (cmd)
    );

    // Task table, search and slice arithmetic.
    rrss_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_task_id       (i_task_id),
        .i_burst_length  (i_burst_length),
        .o_strobe        (o_strobe),
        .o_granted_id    (o_granted_id),
        .o_slice_length  (o_slice_length),
        .o_task_finished (o_task_finished),
        .o_all_done      (o_all_done),
        .o_load_dropped  (o_load_dropped)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/rrss_chk.sv =====
`default_nettype none
`include "round_robin_slice_scheduler_top_defines.svh"

module rrss_chk (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         start,
    input  wire logic                         busy,
    input  wire logic [rrss_pkg::ACT_W-1:0]   i_action,
    input  wire logic                         o_strobe,
    input  wire logic [rrss_pkg::ID_W-1:0]    o_granted_id,
    input  wire logic [rrss_pkg::BURST_W-1:0] o_slice_length,
    input  wire logic                         o_task_finished,
    input  wire logic                         o_all_done,
    input  wire logic                         o_load_dropped
);
    import rrss_pkg::*;

    // An all-done result carries nothing else.
    `RRSS_ASSERT_SAME(a_done_clean, o_strobe && o_all_done, o_granted_id == '0 && o_slice_length == '0 && !o_task_finished && !o_load_dropped, "all-done result has stray fields")

    // A dropped load carries nothing else.
    `RRSS_ASSERT_SAME(a_drop_clean, o_strobe && o_load_dropped, o_granted_id == '0 && o_slice_length == '0 && !o_task_finished && !o_all_done, "dropped-load result has stray fields")

    // A schedule request holds the block busy in the next cycle.
    `RRSS_ASSERT_NEXT(a_sched_busy, start && !busy && i_action == ACT_SCHED, busy, "schedule request did not raise busy")

    // A load or clear request leaves busy low in the next cycle.
    `RRSS_ASSERT_NEXT(a_load_free, start && !busy && (i_action == ACT_LOAD || i_action == ACT_CLEAR), !busy, "load or clear raised busy")

    // A grant only follows a busy cycle of the schedule sequence.
    `RRSS_ASSERT_SAME(a_grant_after_busy, o_strobe && !o_all_done && !o_load_dropped, $past(busy), "grant without a schedule sequence")

endmodule

bind round_robin_slice_scheduler_top rrss_chk u_rrss_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .i_action        (i_action),
    .o_strobe        (o_strobe),
    .o_granted_id    (o_granted_id),
    .o_slice_length  (o_slice_length),
    .o_task_finished (o_task_finished),
    .o_all_done      (o_all_done),
    .o_load_dropped  (o_load_dropped)
);

`default_nettype wire
